// ===== rtl/mads_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mads_pkg
// Shared types and constants for the address dedup set.
// ----------------------------------------------------------------------------
package mads_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = 48;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic {
        FUNC_CHECK = 1'b0,
        FUNC_CLEAR = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_addr wdata;
        t_idx  raddr;
    } t_ram_req;

    typedef struct packed {
        logic valid;
        logic is_new;
        logic was_stored;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/mads_key_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mads_key_ram
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mads_key_ram (
    input  wire                      i_clk,
    input  wire mads_pkg::t_ram_req  i_req,
    output mads_pkg::t_addr          o_rdata
);
    import mads_pkg::*;

    t_addr r_mem [CAPACITY];
    t_addr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/mads_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mads_ctrl
// Scan sequencer: walks the filled entries one per cycle, appends on miss unless full.
// ----------------------------------------------------------------------------
module mads_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire                      i_func,
    input  wire mads_pkg::t_addr     i_bssid,
    input  wire                      i_out_free,
    output mads_pkg::t_result        o_result,
    output mads_pkg::t_ram_req       o_ram_req,
    input  wire mads_pkg::t_addr     i_rdata
);
    import mads_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_fill,  n_fill;
    t_cnt   r_idx,   n_idx;
    t_addr  r_key,   n_key;
    logic   r_is_new, n_is_new;
    logic   r_was_stored, n_was_stored;

    logic acc, is_clear, empty, hit, last, full;

    always_comb begin
        acc      = i_in_valid && (r_state == S_IDLE);
        is_clear = (t_func'(i_func) == FUNC_CLEAR);
        empty    = (r_fill == '0);
        hit      = (i_rdata == r_key);
        last     = (r_idx == r_fill);
        full     = (r_fill == CNT_W'(CAPACITY));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (is_clear || empty) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_key        = r_key;
        n_is_new     = r_is_new;
        n_was_stored = r_was_stored;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (is_clear) begin
                        n_fill       = '0;
                        n_is_new     = 1'b0;
                        n_was_stored = 1'b0;
                    end else if (empty) begin
                        n_fill       = r_fill + 1'b1;
                        n_is_new     = 1'b1;
                        n_was_stored = 1'b1;
                    end else begin
                        n_key = i_bssid;
                        n_idx = CNT_W'(1);
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_is_new     = 1'b0;
                    n_was_stored = 1'b0;
                end else if (last) begin
                    n_is_new     = 1'b1;
                    n_was_stored = !full;
                    if (!full) begin
                        n_fill = r_fill + 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall          = (r_state != S_IDLE);
        o_ram_req.we        = (acc && !is_clear && empty)
                           || ((r_state == S_SCAN) && !hit && last && !full);
        o_ram_req.waddr     = r_fill[IDX_W-1:0];
        o_ram_req.wdata     = (r_state == S_IDLE) ? i_bssid : r_key;
        // prefetch entry zero while idle so the scan starts on accept
        o_ram_req.raddr     = (r_state == S_IDLE) ? '0 : r_idx[IDX_W-1:0];
        o_result.valid      = (r_state == S_DONE) && i_out_free;
        o_result.is_new     = r_is_new;
        o_result.was_stored = r_was_stored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_key        <= n_key;
        r_is_new     <= n_is_new;
        r_was_stored <= n_was_stored;
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx != '0) && (r_idx <= r_fill))
        else $error("scan index outside filled range");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_req.we |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("store write without fill count advance");

    a_stored_is_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.was_stored |-> o_result.is_new)
        else $error("stored address reported as seen");
`endif

endmodule

`default_nettype wire

// ===== rtl/mac_address_dedup_set_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mac_address_dedup_set_top
// Bounded set of 48-bit addresses; reports whether each address is new.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------
//  in      | i_in_valid   | o_in_stall   | i_func, i_bssid
//  out     | o_out_valid  | i_out_stall  | o_is_new, o_was_stored
//
//  A check reads the key store one entry per cycle through its single read
//  port, stopping at a match or after the last filled entry.
//  A clear, or a check on an empty set, skips the scan.
//  Reset empties the set at once; the key store itself is not cleared.
//  A finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module mac_address_dedup_set_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire                  i_func,
    input  wire [47:0]           i_bssid,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_is_new,
    output logic                 o_was_stored
);
    import mads_pkg::*;

    t_ram_req ram_req;
    t_addr    rdata;
    t_result  result;
    logic     out_free;

    logic r_out_valid;
    logic r_is_new;
    logic r_was_stored;

    assign out_free = !r_out_valid || !i_out_stall;

    mads_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_bssid    (i_bssid),
        .i_out_free (out_free),
        .o_result   (result),
        .o_ram_req  (ram_req),
        .i_rdata    (rdata)
    );

    mads_key_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_is_new     <= result.is_new;
            r_was_stored <= result.was_stored;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_new     = r_is_new;
    assign o_was_stored = r_was_stored;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address dedup set. Each accepted word goes
// through a local seen-set predictor. Each output word is compared against
// the oldest predicted verdict. Stimulus mixes directed corner words,
// full-store fills, and random check and clear traffic in three idling phases.
// ----------------------------------------------------------------------------
module tb_top;
    import mads_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 300;
    localparam int RECENT_MAX  = 48;

    typedef struct packed {
        logic is_new;
        logic was_stored;
    } t_verdict;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_func      = FUNC_CHECK;
    logic [ADDR_W-1:0] i_bssid     = '0;
    logic              i_out_stall = 1'b0;
    wire               o_in_stall;
    wire               o_out_valid;
    wire               o_is_new;
    wire               o_was_stored;

    // predictor state
    t_addr       seen_key [CAPACITY];
    int unsigned seen_fill = 0;

    t_verdict verdict_q[$];
    t_addr    recent_addr[$];
    int       snd_idle_pct  = 0;
    int       rcv_stall_pct = 0;
    int       fault_cnt     = 0;
    int       idle_cycles   = 0;

    mac_address_dedup_set_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_bssid      (i_bssid),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_is_new     (o_is_new),
        .o_was_stored (o_was_stored)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_addr rand_addr();
        return t_addr'({$urandom(), $urandom()});
    endfunction

    function automatic t_verdict predict_verdict(input t_func f, input t_addr a);
        t_verdict v;
        logic     hit;
        v   = '0;
        hit = 1'b0;
        if (f == FUNC_CLEAR) begin
            seen_fill = 0;
        end else begin
            for (int k = 0; k < seen_fill; k++) begin
                if (seen_key[k] == a) hit = 1'b1;
            end
            if (!hit) begin
                v.is_new = 1'b1;
                // full store: still new, but drop the address
                if (seen_fill < CAPACITY) begin
                    seen_key[seen_fill] = a;
                    seen_fill++;
                    v.was_stored = 1'b1;
                end
            end
        end
        return v;
    endfunction

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    // Entered and left at a falling edge; valid stays high between words
    // unless a gap is taken.
    task automatic send_word(input t_func f, input t_addr a);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            i_func     <= t_func'($urandom_range(1));
            i_bssid    <= rand_addr();
            do @(negedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_bssid    <= a;
        do @(posedge i_clk); while (o_in_stall);
        verdict_q.push_back(predict_verdict(f, a));
        @(negedge i_clk);
    endtask

    // Hold the input channel idle until every predicted verdict has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_word(FUNC_CHECK, {ADDR_W{1'b0}});
        send_word(FUNC_CHECK, {ADDR_W{1'b0}});
        send_word(FUNC_CHECK, {ADDR_W{1'b1}});
        send_word(FUNC_CHECK, {ADDR_W{1'b1}});
        send_word(FUNC_CHECK, 48'h8000_0000_0000);
        send_word(FUNC_CHECK, 48'h0000_0000_0001);
        send_word(FUNC_CHECK, 48'h7FFF_FFFF_FFFF);
        send_word(FUNC_CHECK, 48'hFFFF_FFFF_FFFE);
        send_word(FUNC_CHECK, 48'h8000_0000_0000);
        send_word(FUNC_CHECK, 48'h0000_0000_0001);
        send_word(FUNC_CLEAR, {ADDR_W{1'b1}});
        // everything is new again after a clear
        send_word(FUNC_CHECK, {ADDR_W{1'b1}});
        send_word(FUNC_CHECK, 48'h7FFF_FFFF_FFFF);
        send_word(FUNC_CLEAR, {ADDR_W{1'b0}});
        send_word(FUNC_CLEAR, rand_addr());
        send_word(FUNC_CHECK, {ADDR_W{1'b0}});
        send_word(FUNC_CHECK, 48'hA5A5_5A5A_A5A5);
        send_word(FUNC_CHECK, 48'h5A5A_A5A5_5A5A);
        send_word(FUNC_CHECK, 48'hA5A5_5A5A_A5A5);
        send_word(FUNC_CHECK, {ADDR_W{1'b0}});
    endtask

    task automatic test_fill_to_capacity();
        t_addr first_a;
        t_addr last_a;
        t_addr spill_a;
        send_word(FUNC_CLEAR, rand_addr());
        first_a = rand_addr();
        last_a  = first_a;
        send_word(FUNC_CHECK, first_a);
        for (int k = 1; k < CAPACITY; k++) begin
            last_a = rand_addr();
            send_word(FUNC_CHECK, last_a);
        end
        send_word(FUNC_CHECK, first_a);
        send_word(FUNC_CHECK, last_a);
        spill_a = rand_addr();
        send_word(FUNC_CHECK, spill_a);
        send_word(FUNC_CHECK, spill_a);
        send_word(FUNC_CHECK, last_a ^ (t_addr'(1) << $urandom_range(ADDR_W - 1)));
        send_word(FUNC_CHECK, rand_addr());
        send_word(FUNC_CHECK, first_a);
        send_word(FUNC_CLEAR, {ADDR_W{1'b0}});
        send_word(FUNC_CHECK, last_a);
        send_word(FUNC_CHECK, spill_a);
        send_word(FUNC_CHECK, last_a);
    endtask

    task automatic test_random_checks(input int n);
        int    pick;
        t_addr a;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) wait_drained();
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_word(FUNC_CLEAR, rand_addr());
            end else begin
                if (pick < 45 && recent_addr.size() != 0) begin
                    a = recent_addr[$urandom_range(recent_addr.size() - 1)];
                end else if (pick < 55 && recent_addr.size() != 0) begin
                    // one bit away from a known address
                    a = recent_addr[$urandom_range(recent_addr.size() - 1)]
                        ^ (t_addr'(1) << $urandom_range(ADDR_W - 1));
                end else if (pick < 58) begin
                    a = $urandom_range(1) ? {ADDR_W{1'b1}} : {ADDR_W{1'b0}};
                end else begin
                    a = rand_addr();
                end
                send_word(FUNC_CHECK, a);
                recent_addr.push_back(a);
                if (recent_addr.size() > RECENT_MAX) void'(recent_addr.pop_front());
            end
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("unexpected word: is_new=%0b was_stored=%0b",
                             o_is_new, o_was_stored);
            end else begin
                exp_v = verdict_q.pop_front();
                if (exp_v.is_new !== o_is_new || exp_v.was_stored !== o_was_stored) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("mismatch: is_new exp=%0b got=%0b, was_stored exp=%0b got=%0b",
                                 exp_v.is_new, o_is_new, exp_v.was_stored, o_was_stored);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(30, 82);
        test_directed();
        test_fill_to_capacity();
        test_random_checks(250);
        wait_drained();

        set_idling(82, 30);
        test_random_checks(350);
        test_fill_to_capacity();
        wait_drained();

        set_idling(0, 0);
        test_random_checks(300);
        wait_drained();

        // catch any stray word after the last verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0 && verdict_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mads_pkg.sv
rtl/mads_key_ram.sv
rtl/mads_ctrl.sv
rtl/mac_address_dedup_set_top.sv
tb/sv/tb_top.sv
